// File: hdl/ppm_pkg.sv
// Shared types, constants and helpers for the per-protocol traffic meter.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package ppm_pkg;

    // Counter width of the statistics rows
    localparam int COUNT_WIDTH = 32;

    // Report rows: total, then IP protocols 4, 17 and 6
    localparam int ROWS  = 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Frame decode constants
    localparam logic [15:0] HDR_BYTES      = 16'd14;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_ALT_MASK = 16'hFF00;
    localparam logic [15:0] ETYPE_ALT_IP   = 16'h1000;

    // Register reset values (five minutes of timestamp milliseconds)
    localparam logic [30:0] INTERVAL_RESET = 31'(5 * 60 * 1000);
    localparam logic [31:0] LIMIT_RESET    = 32'hFFFF_FFFF;

    // Configuration register map (index = paddr[4:3])
    localparam int PADDR_W = 5;
    localparam logic [1:0] REG_TARGET   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    // One captured frame header
    typedef struct packed {
        logic [15:0] frame_length;
        logic [31:0] timestamp;
        logic [47:0] dest_address;
        logic [47:0] source_address;
        logic [15:0] ether_type;
        logic [15:0] ip_total_length;
        logic [7:0]  ip_protocol;
    } frame_t;

    // One report row
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] packets_in;
        logic [31:0] bytes_in;
        logic [31:0] packets_out;
        logic [31:0] bytes_out;
        logic [31:0] elapsed_ms;
        logic        last;
    } report_t;

    // Counters of one statistics row
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] pkts_in;
        logic [COUNT_WIDTH-1:0] bytes_in;
        logic [COUNT_WIDTH-1:0] pkts_out;
        logic [COUNT_WIDTH-1:0] bytes_out;
    } row_counts_t;

    typedef row_counts_t [ROWS-1:0] count_bank_t;

    // Update request from the frame decode to the counter bank
    typedef struct packed {
        logic            en;
        logic [ROWS-1:0] row_hit;
        logic            inc_in;
        logic            inc_out;
        logic [15:0]     bytes;
        logic            clear;
    } count_upd_t;

    // Protocol number shown on a report row
    function automatic logic [7:0] row_proto(input logic [ROW_W-1:0] row);
        logic [7:0] p;
        unique case (row)
            2'd0:    p = 8'd0;
            2'd1:    p = 8'd4;
            2'd2:    p = 8'd17;
            2'd3:    p = 8'd6;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    // Low 32 bits of a counter, zero-extended where the counter is narrower
    function automatic logic [31:0] to_out32(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[31:0];
    endfunction

endpackage

// File: hdl/ppm_frame_if.sv
// Frame header channel of the traffic meter: valid/ready plus one frame_t beat.
// Depends on ppm_pkg.
`timescale 1ns / 1ps

interface ppm_frame_if;
    logic              valid;
    logic              ready;
    ppm_pkg::frame_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ppm_report_if.sv
// Report row channel of the traffic meter: valid/ready plus one report_t beat.
// Depends on ppm_pkg.
`timescale 1ns / 1ps

interface ppm_report_if;
    logic              valid;
    logic              ready;
    ppm_pkg::report_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ppm_count_bank.sv
// Bank of per-row packet and byte counters with a registered update and clear.
// Depends on ppm_pkg.
`timescale 1ns / 1ps

module ppm_count_bank (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppm_pkg::count_upd_t  upd,
    output ppm_pkg::count_bank_t updated
);

    ppm_pkg::count_bank_t counts_reg;
    ppm_pkg::count_bank_t counts_next;

    // Add this beat's contribution to every row it hits
    always_comb
    begin
        for (int r = 0; r < ppm_pkg::ROWS; r++)
        begin
            updated[r] = counts_reg[r];
            if (upd.en && upd.row_hit[r] && upd.inc_in)
            begin
                updated[r].pkts_in  = counts_reg[r].pkts_in + ppm_pkg::COUNT_WIDTH'(1);
                updated[r].bytes_in = counts_reg[r].bytes_in
                                    + ppm_pkg::COUNT_WIDTH'(upd.bytes);
            end
            if (upd.en && upd.row_hit[r] && upd.inc_out)
            begin
                updated[r].pkts_out  = counts_reg[r].pkts_out + ppm_pkg::COUNT_WIDTH'(1);
                updated[r].bytes_out = counts_reg[r].bytes_out
                                     + ppm_pkg::COUNT_WIDTH'(upd.bytes);
            end
        end
    end

    // Drop everything when a report is loaded into the report buffer
    always_comb
    begin
        counts_next = upd.clear ? '0 : updated;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
        end
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        upd.clear |=> counts_reg == '0)
        else $error("counter bank not empty after clear");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !upd.en && !upd.clear |=> $stable(counts_reg))
        else $error("counter bank changed without an update");

    a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> upd.row_hit[0])
        else $error("counted beat misses the total row");

endmodule

// File: hdl/per_protocol_traffic_meter_unit.sv
// Top level of the per-protocol traffic meter: frame decode, interval timing, report buffer.
// Depends on ppm_pkg, ppm_frame_if, ppm_report_if and ppm_count_bank.
`timescale 1ns / 1ps

// The meter takes one frame header beat per cycle unless a frame waits for the
// report buffer. A beat is registered in the input stage, then decoded there and
// counted into the counter bank when the stage advances. When a frame closes an
// interval, the four report rows (total, protocol 4, 17, 6) are snapshotted into
// a report buffer and sent as four beats, the last one flagged. Frames keep being
// accepted while a report drains; only a frame that closes the next interval
// waits for the buffer, until the receiver takes the last row of the report.
// Configuration is an APB port with 64-bit data: target address at 0x00,
// interval at 0x08, sample limit at 0x10. Writing the sample limit reloads the
// report countdown and restarts a stopped meter; write registers only while no
// frame is in flight.

module per_protocol_traffic_meter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    ppm_frame_if.sink                     frame,
    ppm_report_if.source                  report,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppm_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    // Configuration and control state
    logic [47:0] target_reg;
    logic [30:0] interval_reg;
    logic [31:0] limit_reg;
    logic [31:0] left_reg;
    logic        stopped_reg;
    logic [31:0] start_reg;
    logic [31:0] start_next;

    // Input stage
    logic            s1_valid_reg;
    ppm_pkg::frame_t s1_data_reg;

    // Report buffer
    logic                       rpt_valid_reg;
    logic                       rpt_valid_next;
    logic [ppm_pkg::ROW_W-1:0]  row_idx_reg;
    logic [ppm_pkg::ROW_W-1:0]  row_idx_next;
    ppm_pkg::count_bank_t       rpt_rows_reg;
    logic [31:0]                rpt_elapsed_reg;

    // Decode
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;
    logic                  ignore;
    logic                  is_ip;
    logic [15:0]           payload;
    logic [15:0]           bytes;
    logic [31:0]           start_eff;
    logic [31:0]           elapsed;
    logic                  fire;
    logic                  buffer_free;
    logic                  s1_advance;
    logic                  process;
    logic                  load;
    logic                  rpt_take;
    ppm_pkg::count_upd_t   upd;
    ppm_pkg::count_bank_t  updated;

    // APB decode
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            ppm_pkg::REG_TARGET:   prdata = 64'(target_reg);
            ppm_pkg::REG_INTERVAL: prdata = 64'(interval_reg);
            ppm_pkg::REG_LIMIT:    prdata = 64'(limit_reg);
            default:               prdata = '0;
        endcase
    end

    // Frame decode on the registered beat
    always_comb
    begin
        ignore    = stopped_reg || (s1_data_reg.frame_length < ppm_pkg::HDR_BYTES);
        is_ip     = (s1_data_reg.ether_type == ppm_pkg::ETYPE_IPV4)
                 || ((s1_data_reg.ether_type & ppm_pkg::ETYPE_ALT_MASK)
                     == ppm_pkg::ETYPE_ALT_IP);
        payload   = s1_data_reg.frame_length - ppm_pkg::HDR_BYTES;
        bytes     = (s1_data_reg.ip_total_length > payload) ? payload
                                                            : s1_data_reg.ip_total_length;
        start_eff = (start_reg == '0) ? s1_data_reg.timestamp : start_reg;
        elapsed   = s1_data_reg.timestamp - start_eff;
        fire      = !ignore && !elapsed[31] && (elapsed[30:0] >= interval_reg);
    end

    // Advance the input stage unless a report has nowhere to go
    assign rpt_take    = report.valid && report.ready;
    assign buffer_free = !rpt_valid_reg || (rpt_take && row_idx_reg == ppm_pkg::LAST_ROW);
    assign s1_advance  = s1_valid_reg && (!fire || buffer_free);
    assign process     = s1_advance && !ignore;
    assign load        = s1_advance && fire;
    assign frame.ready = !s1_valid_reg || s1_advance;

    // Counter update request
    always_comb
    begin
        upd.en      = process && is_ip;
        upd.inc_in  = s1_data_reg.source_address == target_reg;
        upd.inc_out = s1_data_reg.dest_address == target_reg;
        upd.bytes   = bytes;
        upd.clear   = load;
        for (int r = 0; r < ppm_pkg::ROWS; r++)
        begin
            upd.row_hit[r] = (r == 0)
                || (s1_data_reg.ip_protocol == ppm_pkg::row_proto(ppm_pkg::ROW_W'(r)));
        end
    end

    ppm_count_bank u_count_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (upd),
        .updated (updated)
    );

    // Interval start: take it from the first frame that is not ignored, drop it on a report
    always_comb
    begin
        start_next = start_reg;
        if (process)
        begin
            start_next = fire ? '0 : start_eff;
        end
    end

    // Report buffer sequencing
    always_comb
    begin
        rpt_valid_next = rpt_valid_reg;
        row_idx_next   = row_idx_reg;
        priority if (load)
        begin
            rpt_valid_next = 1'b1;
            row_idx_next   = '0;
        end
        else if (rpt_take)
        begin
            if (row_idx_reg == ppm_pkg::LAST_ROW)
            begin
                rpt_valid_next = 1'b0;
                row_idx_next   = '0;
            end
            else
            begin
                row_idx_next = row_idx_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            interval_reg  <= ppm_pkg::INTERVAL_RESET;
            limit_reg     <= ppm_pkg::LIMIT_RESET;
            left_reg      <= ppm_pkg::LIMIT_RESET;
            stopped_reg   <= 1'b0;
            start_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rpt_valid_reg <= 1'b0;
            row_idx_reg   <= '0;
        end
        else
        begin
            start_reg     <= start_next;
            rpt_valid_reg <= rpt_valid_next;
            row_idx_reg   <= row_idx_next;
            if (frame.ready)
            begin
                s1_valid_reg <= frame.valid;
            end
            if (load)
            begin
                left_reg    <= left_reg - 32'd1;
                stopped_reg <= (left_reg == 32'd1);
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    ppm_pkg::REG_TARGET:   target_reg   <= pwdata[47:0];
                    ppm_pkg::REG_INTERVAL: interval_reg <= pwdata[30:0];
                    ppm_pkg::REG_LIMIT:
                    begin
                        limit_reg   <= pwdata[31:0];
                        left_reg    <= pwdata[31:0];
                        stopped_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            s1_data_reg <= frame.data;
        end
        if (load)
        begin
            rpt_rows_reg    <= updated;
            rpt_elapsed_reg <= elapsed;
        end
    end

    // Present the current report row
    always_comb
    begin
        report.valid            = rpt_valid_reg;
        report.data.protocol    = ppm_pkg::row_proto(row_idx_reg);
        report.data.packets_in  = ppm_pkg::to_out32(rpt_rows_reg[row_idx_reg].pkts_in);
        report.data.bytes_in    = ppm_pkg::to_out32(rpt_rows_reg[row_idx_reg].bytes_in);
        report.data.packets_out = ppm_pkg::to_out32(rpt_rows_reg[row_idx_reg].pkts_out);
        report.data.bytes_out   = ppm_pkg::to_out32(rpt_rows_reg[row_idx_reg].bytes_out);
        report.data.elapsed_ms  = rpt_elapsed_reg;
        report.data.last        = (row_idx_reg == ppm_pkg::LAST_ROW);
    end

    a_no_report_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !load)
        else $error("report loaded while stopped");

    a_idle_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !rpt_valid_reg |-> row_idx_reg == '0)
        else $error("row index off zero with empty report buffer");

    a_start_unset_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> start_reg == '0)
        else $error("interval start kept after report");

    a_last_row_drains: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_take && row_idx_reg == ppm_pkg::LAST_ROW && !load |=> !rpt_valid_reg)
        else $error("report buffer still full after last row");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> buffer_free)
        else $error("report loaded over an undelivered one");

endmodule

// File: tb/sv/tb_per_protocol_traffic_meter_unit.sv
// Self-checking testbench of the per-protocol traffic meter: directed and random frame
// headers, randomly paced on both channels, rows checked against a cycle-free predictor.
// Depends on ppm_pkg, ppm_frame_if, ppm_report_if and per_protocol_traffic_meter_unit.
`timescale 1ns / 1ps

module tb_per_protocol_traffic_meter_unit;

    localparam logic [7:0] PROTO_TOTAL = 8'd0;
    localparam logic [7:0] PROTO_IPIP  = 8'd4;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] ROW_PROTO [ppm_pkg::ROWS] =
        '{PROTO_TCP, PROTO_UDP, PROTO_IPIP, PROTO_TOTAL};

    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [47:0] ALL_ONES_ADDR = 48'hFFFF_FFFF_FFFF;

    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHUNKS = 9;
    localparam int CHUNK_ITEMS   = 35;
    localparam int CYCLE_LIMIT   = 300000;

    logic clk = 1'b0;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ppm_pkg::PADDR_W-1:0]   paddr;
    logic [63:0]                   pwdata;
    logic [63:0]                   prdata;
    logic                          pready;

    ppm_frame_if  frame_ch ();
    ppm_report_if report_ch ();

    per_protocol_traffic_meter_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .report  (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Predictor state: configuration copy, interval start and counter rows
    logic [47:0]                     cfg_target;
    logic [30:0]                     cfg_interval;
    logic [31:0]                     reports_left;
    logic                            meter_stopped;
    logic [31:0]                     span_start;
    logic [ppm_pkg::COUNT_WIDTH-1:0] pkts_in   [ppm_pkg::ROWS];
    logic [ppm_pkg::COUNT_WIDTH-1:0] octets_in [ppm_pkg::ROWS];
    logic [ppm_pkg::COUNT_WIDTH-1:0] pkts_out  [ppm_pkg::ROWS];
    logic [ppm_pkg::COUNT_WIDTH-1:0] octets_out[ppm_pkg::ROWS];

    ppm_pkg::frame_t  frames_pending[$];
    ppm_pkg::report_t rows_due[$];

    logic [31:0] stamp_ms;
    logic        sender_paced;
    logic        receiver_paced;
    logic        hold_arm;
    logic        frame_beat_taken;
    logic        report_beat_taken;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          tx_gap = 0;
    int          rx_stall = 0;

    int mismatches     = 0;
    int frames_taken   = 0;
    int rows_checked   = 0;
    int reports_seen   = 0;
    int reg_writes     = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;

    function automatic int proto_row(input logic [7:0] proto);
        case (proto)
            PROTO_IPIP: return 1;
            PROTO_UDP:  return 2;
            PROTO_TCP:  return 3;
            default:    return -1;
        endcase
    endfunction

    // Apply one accepted frame to the predictor and queue any report rows it fires
    task automatic meter_frame(input ppm_pkg::frame_t f);
        logic [15:0]              payload;
        logic [15:0]              nbytes;
        logic [31:0]              elapsed;
        logic [ppm_pkg::ROWS-1:0] hit;
        int                       prow;
        ppm_pkg::report_t         row;
        if (meter_stopped || f.frame_length < ppm_pkg::HDR_BYTES)
            return;
        if (span_start == 32'd0)
            span_start = f.timestamp;
        if (f.ether_type == ppm_pkg::ETYPE_IPV4
            || (f.ether_type & ppm_pkg::ETYPE_ALT_MASK) == ppm_pkg::ETYPE_ALT_IP)
        begin
            payload = f.frame_length - ppm_pkg::HDR_BYTES;
            nbytes  = (f.ip_total_length > payload) ? payload : f.ip_total_length;
            prow    = proto_row(f.ip_protocol);
            hit     = '0;
            hit[0]  = 1'b1;
            if (prow >= 0)
                hit[prow] = 1'b1;
            for (int r = 0; r < ppm_pkg::ROWS; r++)
            begin
                if (hit[r] && f.source_address == cfg_target)
                begin
                    pkts_in[r]   = pkts_in[r] + 1'b1;
                    octets_in[r] = octets_in[r] + nbytes;
                end
                if (hit[r] && f.dest_address == cfg_target)
                begin
                    pkts_out[r]   = pkts_out[r] + 1'b1;
                    octets_out[r] = octets_out[r] + nbytes;
                end
            end
        end
        // Fire only on a non-negative elapsed time that reaches the interval
        elapsed = f.timestamp - span_start;
        if (elapsed[31] || elapsed < {1'b0, cfg_interval})
            return;
        for (int r = 0; r < ppm_pkg::ROWS; r++)
        begin
            row.protocol    = ROW_PROTO[ppm_pkg::ROWS - 1 - r];
            row.packets_in  = 32'(pkts_in[r]);
            row.bytes_in    = 32'(octets_in[r]);
            row.packets_out = 32'(pkts_out[r]);
            row.bytes_out   = 32'(octets_out[r]);
            row.elapsed_ms  = elapsed;
            row.last        = (r == ppm_pkg::ROWS - 1);
            rows_due.push_back(row);
            pkts_in[r]    = '0;
            octets_in[r]  = '0;
            pkts_out[r]   = '0;
            octets_out[r] = '0;
        end
        span_start   = 32'd0;
        reports_left = reports_left - 1'b1;
        if (reports_left == 32'd0)
            meter_stopped = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ppm_pkg::REG_TARGET:   cfg_target = value[47:0];
            ppm_pkg::REG_INTERVAL: cfg_interval = value[30:0];
            ppm_pkg::REG_LIMIT:
            begin
                reports_left  = value[31:0];
                meter_stopped = 1'b0;
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic offer_frame(input logic [15:0] len, input logic [31:0] ts,
                               input logic [47:0] dst, input logic [47:0] src,
                               input logic [15:0] etype, input logic [15:0] iplen,
                               input logic [7:0] proto);
        ppm_pkg::frame_t f;
        f.frame_length    = len;
        f.timestamp       = ts;
        f.dest_address    = dst;
        f.source_address  = src;
        f.ether_type      = etype;
        f.ip_total_length = iplen;
        f.ip_protocol     = proto;
        frames_pending.push_back(f);
    endtask

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly well-formed IP traffic around the target on a running clock, some noise
    task automatic random_frame();
        logic [15:0] len;
        logic [15:0] etype;
        logic [15:0] iplen;
        logic [31:0] ts;
        logic [47:0] dst;
        logic [47:0] src;
        logic [7:0]  proto;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            len = 16'($urandom_range(0, 13));
        else if (pick < 15)
            len = 16'($urandom);
        else
            len = 16'($urandom_range(14, 1514));
        stamp_ms = stamp_ms + $urandom_range(0, 40);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            ts = $urandom;
        else if (pick < 6)
            ts = 32'd0;
        else
            ts = stamp_ms;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            etype = ppm_pkg::ETYPE_IPV4;
        else if (pick < 75)
            etype = ppm_pkg::ETYPE_ALT_IP | 16'($urandom_range(0, 255));
        else
            etype = 16'($urandom);
        iplen = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, len)) : 16'($urandom);
        case ($urandom_range(0, 5))
            0:       proto = PROTO_IPIP;
            1:       proto = PROTO_UDP;
            2:       proto = PROTO_TCP;
            3:       proto = PROTO_TOTAL;
            default: proto = 8'($urandom);
        endcase
        src = ($urandom_range(0, 99) < 45) ? cfg_target : rand_addr();
        dst = ($urandom_range(0, 99) < 45) ? cfg_target : rand_addr();
        offer_frame(len, ts, dst, src, etype, iplen, proto);
    endtask

    // Hold until every queued frame is sent and every expected row has arrived
    task automatic wait_drained();
        do @(posedge clk);
        while (frames_pending.size() != 0 || frame_ch.valid || rows_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Frame driver: advance on each taken beat, insert the drawn gap before the next
    always @(negedge clk)
    begin
        logic offer;
        if (!rst_n)
        begin
            frame_ch.valid <= 1'b0;
        end
        else
        begin
            offer = frame_ch.valid && !frame_beat_taken;
            if (!offer)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (frames_pending.size() != 0)
                begin
                    frame_ch.data <= frames_pending.pop_front();
                    offer = 1'b1;
                    tx_gap = sender_paced ? $urandom_range(0, MAX_GAP) : 0;
                end
            end
            frame_ch.valid <= offer;
        end
    end

    // Frame monitor: predict rows for every accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_beat_taken <= 1'b0;
        end
        else
        begin
            frame_beat_taken <= frame_ch.valid && frame_ch.ready;
            if (frame_ch.valid && frame_ch.ready)
            begin
                meter_frame(frame_ch.data);
                frames_taken++;
            end
            if (frame_ch.valid && !frame_ch.ready)
                input_stalls++;
        end
    end

    // Long receiver hold-off, armed once by the stimulus
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Report receiver: drop ready for a drawn stall after each beat
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
        end
        else
        begin
            if (report_beat_taken)
                rx_stall = receiver_paced ? $urandom_range(0, MAX_GAP) : 0;
            report_ch.ready <= (rx_stall == 0) && (hold_left == 0);
            if (rx_stall > 0)
                rx_stall--;
        end
    end

    // Report monitor: compare each row with the oldest expectation
    always @(posedge clk)
    begin
        ppm_pkg::report_t want;
        if (!rst_n)
        begin
            report_beat_taken <= 1'b0;
        end
        else
        begin
            report_beat_taken <= report_ch.valid && report_ch.ready;
            if (report_ch.valid && report_ch.ready)
            begin
                if (rows_due.size() == 0)
                begin
                    $display("%0t: unexpected report row, expected none, got %0h",
                             $time, report_ch.data);
                    mismatches++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    check_field("protocol", 32'(want.protocol), 32'(report_ch.data.protocol));
                    check_field("packets_in", want.packets_in, report_ch.data.packets_in);
                    check_field("bytes_in", want.bytes_in, report_ch.data.bytes_in);
                    check_field("packets_out", want.packets_out, report_ch.data.packets_out);
                    check_field("bytes_out", want.bytes_out, report_ch.data.bytes_out);
                    check_field("elapsed_ms", want.elapsed_ms, report_ch.data.elapsed_ms);
                    check_field("last", 32'(want.last), 32'(report_ch.data.last));
                    rows_checked++;
                    if (want.last)
                        reports_seen++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [47:0] station;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sender_paced   = 1'b1;
        receiver_paced = 1'b1;
        hold_arm       = 1'b0;
        stamp_ms       = 32'd1000;
        cfg_target     = '0;
        cfg_interval   = ppm_pkg::INTERVAL_RESET;
        reports_left   = ppm_pkg::LIMIT_RESET;
        meter_stopped  = 1'b0;
        span_start     = 32'd0;
        for (int r = 0; r < ppm_pkg::ROWS; r++)
        begin
            pkts_in[r]    = '0;
            octets_in[r]  = '0;
            pkts_out[r]   = '0;
            octets_out[r] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: short frames, zero-timestamp start, clipping, non-IP, protocols
        offer_frame(16'd0, 32'd100, '0, '0, ppm_pkg::ETYPE_IPV4, 16'd20, PROTO_TCP);
        offer_frame(16'd13, 32'd100, '0, '0, ppm_pkg::ETYPE_IPV4, 16'd20, PROTO_TCP);
        offer_frame(16'd60, 32'd0, '0, 48'h1234_5678_9ABC, ppm_pkg::ETYPE_IPV4, 16'd46,
                    PROTO_TCP);
        offer_frame(16'd14, 32'd5, '0, '0, ppm_pkg::ETYPE_ALT_IP, 16'hFFFF, PROTO_UDP);
        offer_frame(16'd1514, 32'd1000, rand_addr(), '0, 16'h10FF, 16'd1500, PROTO_IPIP);
        offer_frame(16'd100, 32'd2000, '0, '0, ETYPE_IPV6, 16'd80, PROTO_UDP);
        offer_frame(16'd200, 32'd3000, rand_addr(), '0, ppm_pkg::ETYPE_IPV4, 16'd300,
                    PROTO_TOTAL);
        offer_frame(16'd200, 32'd4000, '0, rand_addr(), ppm_pkg::ETYPE_IPV4, 16'd150, 8'd255);
        offer_frame(16'd64, 32'd300004, rand_addr(), '0, ppm_pkg::ETYPE_IPV4, 16'd50,
                    PROTO_TCP);
        offer_frame(16'd64, 32'd300005, '0, rand_addr(), ppm_pkg::ETYPE_IPV4, 16'd50,
                    PROTO_TCP);
        wait_drained();

        // Widest settings: all-ones station, longest interval, zero limit
        reg_write(ppm_pkg::REG_TARGET, {16'd0, ALL_ONES_ADDR});
        reg_write(ppm_pkg::REG_INTERVAL, 64'h7FFF_FFFF);
        reg_write(ppm_pkg::REG_LIMIT, 64'd0);
        reg_write(REG_UNUSED, {$urandom, $urandom});
        offer_frame(16'hFFFF, 32'd1, ALL_ONES_ADDR, ALL_ONES_ADDR, ppm_pkg::ETYPE_IPV4,
                    16'hFFFF, PROTO_TCP);
        offer_frame(16'd80, 32'd0, rand_addr(), ALL_ONES_ADDR, ppm_pkg::ETYPE_IPV4, 16'd66,
                    PROTO_UDP);
        offer_frame(16'd80, 32'h8000_0000, ALL_ONES_ADDR, rand_addr(), 16'h1034, 16'd40,
                    PROTO_IPIP);
        offer_frame(16'd80, 32'hFFFF_FFFF, rand_addr(), ALL_ONES_ADDR, ppm_pkg::ETYPE_IPV4,
                    16'd60, PROTO_TCP);
        wait_drained();

        // Timestamp wrap across the interval
        reg_write(ppm_pkg::REG_INTERVAL, 64'h20);
        offer_frame(16'd90, 32'h0000_001F, rand_addr(), ALL_ONES_ADDR, ppm_pkg::ETYPE_IPV4,
                    16'd76, PROTO_UDP);
        wait_drained();

        // Zero interval with a limit of two: stop, then restart by rewriting the limit
        station = rand_addr();
        reg_write(ppm_pkg::REG_TARGET, {16'd0, station});
        reg_write(ppm_pkg::REG_INTERVAL, 64'd0);
        reg_write(ppm_pkg::REG_LIMIT, 64'd2);
        offer_frame(16'd70, 32'd0, rand_addr(), station, ppm_pkg::ETYPE_IPV4, 16'd56,
                    PROTO_TCP);
        offer_frame(16'd70, 32'd77, station, rand_addr(), ppm_pkg::ETYPE_IPV4, 16'd56,
                    PROTO_UDP);
        offer_frame(16'd70, 32'd78, station, station, ppm_pkg::ETYPE_IPV4, 16'd56, PROTO_IPIP);
        wait_drained();
        reg_write(ppm_pkg::REG_LIMIT, {32'd0, ppm_pkg::LIMIT_RESET});
        offer_frame(16'd70, 32'd79, station, station, ppm_pkg::ETYPE_IPV4, 16'd56, PROTO_IPIP);
        wait_drained();

        // Every frame at least a header long fires while the receiver holds off: fill the report path
        reg_write(ppm_pkg::REG_LIMIT, 64'd0);
        sender_paced = 1'b0;
        hold_arm     = 1'b1;
        for (int n = 0; n < 24; n++)
            random_frame();
        wait_drained();

        // Random traffic in chunks, settings redrawn between chunks
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            case ($urandom_range(0, 5))
                0:       station = '0;
                1:       station = ALL_ONES_ADDR;
                default: station = rand_addr();
            endcase
            reg_write(ppm_pkg::REG_TARGET, {16'd0, station});
            case ($urandom_range(0, 7))
                0:       reg_write(ppm_pkg::REG_INTERVAL, 64'd0);
                1:       reg_write(ppm_pkg::REG_INTERVAL,
                                   64'($urandom_range(0, 32'h7FFF_FFFF)));
                default: reg_write(ppm_pkg::REG_INTERVAL, 64'($urandom_range(10, 150)));
            endcase
            if ($urandom_range(0, 4) == 0)
                reg_write(ppm_pkg::REG_LIMIT, 64'($urandom_range(1, 4)));
            else
                reg_write(ppm_pkg::REG_LIMIT, 64'($urandom));
            if ($urandom_range(0, 3) == 0)
                reg_write(REG_UNUSED, {$urandom, $urandom});
            sender_paced   = ($urandom_range(0, 3) != 0);
            receiver_paced = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < CHUNK_ITEMS; n++)
                random_frame();
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d frame beats, %0d report rows in %0d reports, %0d register writes.",
                 frames_taken, rows_checked, reports_seen, reg_writes);
        $display("Frame input stalled for %0d cycles, including a %0d-cycle receiver hold.",
                 input_stalls, HOLD_CYCLES);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/ppm_pkg.sv
hdl/ppm_frame_if.sv
hdl/ppm_report_if.sv
hdl/ppm_count_bank.sv
hdl/per_protocol_traffic_meter_unit.sv
tb/sv/tb_per_protocol_traffic_meter_unit.sv
